// ===== rtl/bfpa_pkg.sv =====
`default_nettype none

package bfpa_pkg;

  // Default number of partition entries in the table.
  localparam int unsigned Partitions = 8;

  // Field widths of the request and result items.
  localparam int unsigned OwnerW = 6;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned PartW  = 3;
  localparam int unsigned TypeW  = 2;
  localparam int unsigned StatW  = 3;

  // Request types.
  localparam logic [TypeW-1:0] ReqAlloc   = 2'd0;
  localparam logic [TypeW-1:0] ReqRelease = 2'd1;
  localparam logic [TypeW-1:0] ReqDefine  = 2'd2;

  // Result status codes.
  localparam logic [StatW-1:0] StAllocated = 3'd0;
  localparam logic [StatW-1:0] StTooBig    = 3'd1;
  localparam logic [StatW-1:0] StMemFull   = 3'd2;
  localparam logic [StatW-1:0] StReleased  = 3'd3;
  localparam logic [StatW-1:0] StNothing   = 3'd4;
  localparam logic [StatW-1:0] StDefined   = 3'd5;

  // Scan probe that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic              is_rel;     // release scan when set, allocate scan otherwise
    logic [OwnerW-1:0] owner;
    logic [SizeW-1:0]  req_size;
    logic [SizeW-1:0]  max_size;   // largest size seen so far, free or busy
    logic              found;
    logic [SizeW-1:0]  best_size;
    logic [AddrW-1:0]  best_base;
  } probe_t;

  // Table update command broadcast to all cells.
  typedef struct packed {
    logic              wr_def;     // load base and size, mark free
    logic              set_busy;   // allocation commit
    logic              clr_busy;   // release commit
    logic [OwnerW-1:0] owner;
    logic [AddrW-1:0]  base;
    logic [SizeW-1:0]  size;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bfpa_cell.sv =====
`default_nettype none

module bfpa_cell #(
  parameter int unsigned Partitions = bfpa_pkg::Partitions,
  parameter int unsigned CellIdx    = 0
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              probe_valid_i,
  input  bfpa_pkg::probe_t                 probe_i,
  input  wire [((Partitions > 1) ? $clog2(Partitions) : 1)-1:0] probe_idx_i,
  output logic                             probe_valid_o,
  output bfpa_pkg::probe_t                 probe_o,
  output logic [((Partitions > 1) ? $clog2(Partitions) : 1)-1:0] probe_idx_o,
  input  bfpa_pkg::cmd_t                   cmd_i,
  input  wire [((Partitions > 1) ? $clog2(Partitions) : 1)-1:0] cmd_idx_i
);

  localparam int unsigned IdxW = (Partitions > 1) ? $clog2(Partitions) : 1;
  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  // Entry held by this cell.
  logic [bfpa_pkg::SizeW-1:0]  size_q;
  logic [bfpa_pkg::AddrW-1:0]  base_q;
  logic                        busy_q;
  logic [bfpa_pkg::OwnerW-1:0] owner_q;

  bfpa_pkg::probe_t  probe_d;
  logic [IdxW-1:0]   idx_d;
  logic              hit;

  // Fold this entry into the passing probe.
  always_comb begin
    probe_d = probe_i;
    idx_d   = probe_idx_i;
    if (!probe_i.is_rel) begin
      if (size_q > probe_i.max_size) begin
        probe_d.max_size = size_q;
      end
      if (!busy_q && (size_q >= probe_i.req_size) &&
          (!probe_i.found || (size_q < probe_i.best_size))) begin
        probe_d.found     = 1'b1;
        probe_d.best_size = size_q;
        probe_d.best_base = base_q;
        idx_d             = MyIdx;
      end
    end else if (!probe_i.found && busy_q && (owner_q == probe_i.owner)) begin
      probe_d.found     = 1'b1;
      probe_d.best_size = size_q;
      probe_d.best_base = base_q;
      idx_d             = MyIdx;
    end
  end

  // Probe stage toward the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_valid_o <= 1'b0;
    end else begin
      probe_valid_o <= probe_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_o     <= probe_d;
    probe_idx_o <= idx_d;
  end

  assign hit = (cmd_idx_i == MyIdx);

  // Entry updates from define and commit commands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
      base_q <= '0;
      busy_q <= 1'b0;
    end else if (hit) begin
      if (cmd_i.wr_def) begin
        size_q <= cmd_i.size;
        base_q <= cmd_i.base;
        busy_q <= 1'b0;
      end else if (cmd_i.set_busy) begin
        busy_q <= 1'b1;
      end else if (cmd_i.clr_busy) begin
        busy_q <= 1'b0;
      end
    end
  end

  // The owner is only read while the entry is busy, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (hit && cmd_i.set_busy) begin
      owner_q <= cmd_i.owner;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/best_fit_partition_allocator_core.sv =====
`default_nettype none

// Channel   Dir  Payload
// s_axis    in   tuser: req_type; tdata: owner_id, request_size, part_index, def_base, def_size
// m_axis    out  tuser: status; tdata: chosen_partition, chosen_base, chosen_size
//
// Allocate and release requests send a probe down the chain of cells, one cell per cycle,
// and their result is registered from the chain's last cell; define and unknown requests
// show their result in the cycle after the request is taken. One request is in flight at
// a time and the next is taken in the cycle after the result has been delivered.
// Reset clears the table at once; a stalled result holds until m_axis_tready is seen.
module best_fit_partition_allocator_core #(
  parameter int unsigned Partitions = bfpa_pkg::Partitions
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [5:0] owner_id, [21:6] request_size, [24:22] part_index,
  // [40:25] def_base, [56:41] def_size, [63:57] zero
  input  wire  [63:0] s_axis_tdata_i,
  // [1:0] req_type
  input  wire  [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // [2:0] chosen_partition, [18:3] chosen_base, [34:19] chosen_size, [39:35] zero
  output logic [39:0] m_axis_tdata_o,
  // [2:0] status
  output logic [2:0]  m_axis_tuser_o
);

  localparam int unsigned IdxW = (Partitions > 1) ? $clog2(Partitions) : 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  // Request fields.
  logic [bfpa_pkg::TypeW-1:0]  req_type;
  logic [bfpa_pkg::OwnerW-1:0] owner_id;
  logic [bfpa_pkg::SizeW-1:0]  request_size;
  logic [bfpa_pkg::PartW-1:0]  part_index;
  logic [bfpa_pkg::AddrW-1:0]  def_base;
  logic [bfpa_pkg::SizeW-1:0]  def_size;

  assign req_type     = s_axis_tuser_i;
  assign owner_id     = s_axis_tdata_i[5:0];
  assign request_size = s_axis_tdata_i[21:6];
  assign part_index   = s_axis_tdata_i[24:22];
  assign def_base     = s_axis_tdata_i[40:25];
  assign def_size     = s_axis_tdata_i[56:41];

  logic [1:0] state_q, state_d;
  logic       accept;
  logic       def_in_range;

  // Result register.
  logic [bfpa_pkg::StatW-1:0] status_q, status_d;
  logic [bfpa_pkg::PartW-1:0] part_q, part_d;
  logic [bfpa_pkg::AddrW-1:0] base_q, base_d;
  logic [bfpa_pkg::SizeW-1:0] size_q, size_d;

  // Cell chain.
  logic             chain_valid [Partitions+1];
  bfpa_pkg::probe_t chain_probe [Partitions+1];
  logic [IdxW-1:0]  chain_idx   [Partitions+1];
  bfpa_pkg::probe_t head_probe;

  bfpa_pkg::cmd_t   cmd;
  logic [IdxW-1:0]  cmd_idx;

  logic             tail_valid;
  bfpa_pkg::probe_t tail;
  logic [IdxW-1:0]  tail_idx;

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign def_in_range    = ({1'b0, part_index} < 4'(Partitions > 15 ? 15 : Partitions)) ||
                           (Partitions > 8);

  // Probe injected at the head of the chain.
  assign chain_valid[0] = accept &&
                          ((req_type == bfpa_pkg::ReqAlloc) || (req_type == bfpa_pkg::ReqRelease));
  always_comb begin
    head_probe          = '0;
    head_probe.is_rel   = (req_type == bfpa_pkg::ReqRelease);
    head_probe.owner    = owner_id;
    head_probe.req_size = request_size;
  end

  assign chain_probe[0] = head_probe;
  assign chain_idx[0]   = '0;

  for (genvar g = 0; g < Partitions; g++) begin : g_cell
    bfpa_cell #(
      .Partitions (Partitions),
      .CellIdx    (g)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .probe_valid_i (chain_valid[g]),
      .probe_i       (chain_probe[g]),
      .probe_idx_i   (chain_idx[g]),
      .probe_valid_o (chain_valid[g+1]),
      .probe_o       (chain_probe[g+1]),
      .probe_idx_o   (chain_idx[g+1]),
      .cmd_i         (cmd),
      .cmd_idx_i     (cmd_idx)
    );
  end

  assign tail_valid = chain_valid[Partitions];
  assign tail       = chain_probe[Partitions];
  assign tail_idx   = chain_idx[Partitions];

  // Table commands and next result.
  always_comb begin
    cmd      = '0;
    cmd_idx  = '0;
    status_d = status_q;
    part_d   = part_q;
    base_d   = base_q;
    size_d   = size_q;
    state_d  = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          status_d = bfpa_pkg::StNothing;
          part_d   = '0;
          base_d   = '0;
          size_d   = '0;
          if ((req_type == bfpa_pkg::ReqAlloc) || (req_type == bfpa_pkg::ReqRelease)) begin
            state_d = StScan;
          end else begin
            state_d = StOut;
            if (req_type == bfpa_pkg::ReqDefine) begin
              status_d = bfpa_pkg::StDefined;
              if (def_in_range) begin
                cmd.wr_def = 1'b1;
                cmd.base   = def_base;
                cmd.size   = def_size;
                cmd_idx    = IdxW'(part_index);
                part_d     = part_index;
                base_d     = def_base;
                size_d     = def_size;
              end
            end
          end
        end
      end
      StScan: begin
        if (tail_valid) begin
          state_d = StOut;
          cmd_idx = tail_idx;
          if (tail.is_rel) begin
            if (tail.found) begin
              cmd.clr_busy = 1'b1;
              status_d     = bfpa_pkg::StReleased;
              part_d       = bfpa_pkg::PartW'(tail_idx);
              base_d       = tail.best_base;
              size_d       = tail.best_size;
            end else begin
              status_d = bfpa_pkg::StNothing;
            end
          end else if (tail.req_size > tail.max_size) begin
            status_d = bfpa_pkg::StTooBig;
          end else if (tail.found) begin
            cmd.set_busy = 1'b1;
            cmd.owner    = tail.owner;
            status_d     = bfpa_pkg::StAllocated;
            part_d       = bfpa_pkg::PartW'(tail_idx);
            base_d       = tail.best_base;
            size_d       = tail.best_size;
          end else begin
            status_d = bfpa_pkg::StMemFull;
          end
        end
      end
      StOut: begin
        if (m_axis_tready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    part_q   <= part_d;
    base_q   <= base_d;
    size_q   <= size_d;
  end

  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {5'b0, size_q, base_q, part_q};

endmodule

`default_nettype wire

// ===== tb/best_fit_partition_allocator_core_test.sv =====
`timescale 1ns / 1ps

module best_fit_partition_allocator_core_test;

  // The request type that the block does not decode.
  localparam logic [bfpa_pkg::TypeW-1:0] ReqUnknown = 2'd3;

  // Number of random requests after the directed table.
  localparam int RandomCount = 600;
  // Requests at the end of the run that are sent without any idling.
  localparam int SteadyCount = 100;
  // A full drain of the pipeline is forced this often during the random part.
  localparam int DrainEvery = 150;

  // One request, one field per member.
  typedef struct packed {
    logic [bfpa_pkg::TypeW-1:0]  kind;
    logic [bfpa_pkg::OwnerW-1:0] owner;
    logic [bfpa_pkg::SizeW-1:0]  need;
    logic [bfpa_pkg::PartW-1:0]  slot;
    logic [bfpa_pkg::AddrW-1:0]  base;
    logic [bfpa_pkg::SizeW-1:0]  span;
  } request_t;

  // One reply of the block.
  typedef struct packed {
    logic [bfpa_pkg::StatW-1:0] status;
    logic [bfpa_pkg::PartW-1:0] slot;
    logic [bfpa_pkg::AddrW-1:0] base;
    logic [bfpa_pkg::SizeW-1:0] span;
  } reply_t;

  // One row of the directed table; the reply is typed in only when known is set.
  typedef struct packed {
    request_t req;
    logic     known;
    reply_t   reply;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  // Shadow copy of the partition table.
  logic [bfpa_pkg::SizeW-1:0]  table_span  [bfpa_pkg::Partitions];
  logic [bfpa_pkg::AddrW-1:0]  table_base  [bfpa_pkg::Partitions];
  logic                        table_busy  [bfpa_pkg::Partitions];
  logic [bfpa_pkg::OwnerW-1:0] table_owner [bfpa_pkg::Partitions];

  reply_t reply_q [$];
  row_t   directed_rows [$];
  reply_t head_reply;
  int     mismatch_count;
  bit     steady_tail;

  best_fit_partition_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Computes the reply of the block to one request and updates the shadow table.
  function automatic reply_t predict_reply(request_t r);
    reply_t                     rep;
    logic [bfpa_pkg::SizeW-1:0] biggest;
    logic [bfpa_pkg::SizeW-1:0] best_span;
    int                         best;
    rep       = '0;
    biggest   = '0;
    best_span = '0;
    best      = -1;
    case (r.kind)
      bfpa_pkg::ReqAlloc: begin
        for (int i = 0; i < bfpa_pkg::Partitions; i++) begin
          if (table_span[i] > biggest) biggest = table_span[i];
        end
        if (r.need > biggest) begin
          rep.status = bfpa_pkg::StTooBig;
        end else begin
          // Smallest free entry that fits; a strict compare keeps the lowest index on a tie.
          for (int i = 0; i < bfpa_pkg::Partitions; i++) begin
            if (!table_busy[i] && table_span[i] >= r.need &&
                (best < 0 || table_span[i] < best_span)) begin
              best      = i;
              best_span = table_span[i];
            end
          end
          if (best < 0) begin
            rep.status = bfpa_pkg::StMemFull;
          end else begin
            table_busy[best]  = 1'b1;
            table_owner[best] = r.owner;
            rep.status = bfpa_pkg::StAllocated;
            rep.slot   = bfpa_pkg::PartW'(best);
            rep.base   = table_base[best];
            rep.span   = table_span[best];
          end
        end
      end
      bfpa_pkg::ReqRelease: begin
        rep.status = bfpa_pkg::StNothing;
        for (int i = 0; i < bfpa_pkg::Partitions; i++) begin
          if (best < 0 && table_busy[i] && table_owner[i] == r.owner) begin
            best          = i;
            table_busy[i] = 1'b0;
            rep.status    = bfpa_pkg::StReleased;
            rep.slot      = bfpa_pkg::PartW'(i);
            rep.base      = table_base[i];
            rep.span      = table_span[i];
          end
        end
      end
      bfpa_pkg::ReqDefine: begin
        rep.status = bfpa_pkg::StDefined;
        if (int'(r.slot) < bfpa_pkg::Partitions) begin
          table_base[r.slot] = r.base;
          table_span[r.slot] = r.span;
          table_busy[r.slot] = 1'b0;
          rep.slot = r.slot;
          rep.base = r.base;
          rep.span = r.span;
        end
      end
      default: begin
        rep.status = bfpa_pkg::StNothing;
      end
    endcase
    return rep;
  endfunction

  // Builds one random request, biased toward sizes that collide and owners that repeat.
  function automatic request_t random_request();
    request_t r;
    int       pick;
    r       = '0;
    r.owner = ($urandom_range(0, 4) == 0) ? bfpa_pkg::OwnerW'($urandom_range(0, 63))
                                          : bfpa_pkg::OwnerW'($urandom_range(0, 7));
    r.slot  = bfpa_pkg::PartW'($urandom_range(0, 7));
    r.base  = bfpa_pkg::AddrW'($urandom);
    case ($urandom_range(0, 9))
      0:       r.span = '0;
      1:       r.span = '1;
      2, 3:    r.span = bfpa_pkg::SizeW'($urandom);
      default: r.span = bfpa_pkg::SizeW'($urandom_range(1, 8) * 64);
    endcase
    case ($urandom_range(0, 9))
      0:          r.need = '0;
      1:          r.need = '1;
      2:          r.need = bfpa_pkg::SizeW'($urandom);
      3, 4, 5:    r.need = table_span[$urandom_range(0, bfpa_pkg::Partitions - 1)];
      default:    r.need = bfpa_pkg::SizeW'($urandom_range(1, 8) * 64 - $urandom_range(0, 63));
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      r.kind = bfpa_pkg::ReqDefine;
    end else if (pick < 60) begin
      r.kind = bfpa_pkg::ReqAlloc;
    end else if (pick < 95) begin
      r.kind = bfpa_pkg::ReqRelease;
    end else begin
      r.kind = ReqUnknown;
    end
    return r;
  endfunction

  task automatic add_row(input logic [bfpa_pkg::TypeW-1:0] kind, input int owner,
                         input int need, input int slot, input int base, input int span,
                         input bit known, input logic [bfpa_pkg::StatW-1:0] st,
                         input int rslot, input int rbase, input int rspan);
    row_t row;
    row.req.kind    = kind;
    row.req.owner   = bfpa_pkg::OwnerW'(owner);
    row.req.need    = bfpa_pkg::SizeW'(need);
    row.req.slot    = bfpa_pkg::PartW'(slot);
    row.req.base    = bfpa_pkg::AddrW'(base);
    row.req.span    = bfpa_pkg::SizeW'(span);
    row.known       = known;
    row.reply.status = st;
    row.reply.slot   = bfpa_pkg::PartW'(rslot);
    row.reply.base   = bfpa_pkg::AddrW'(rbase);
    row.reply.span   = bfpa_pkg::SizeW'(rspan);
    directed_rows.push_back(row);
  endtask

  // Presents one request and records its reply once the block takes it.
  task automatic send_request(input request_t r, input bit known, input reply_t typed);
    reply_t predicted;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, r.span, r.base, r.slot, r.need, r.owner};
    s_axis_tuser_i  <= r.kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = predict_reply(r);
    reply_q.push_back(known ? typed : predicted);
  endtask

  // Optional idle burst on the request side before the next request.
  task automatic request_gap(input bit drain);
    if (drain) begin
      s_axis_tvalid_i <= 1'b0;
      wait (reply_q.size() == 0);
      @(posedge clk_i);
    end else if (!steady_tail && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Reply checker: every reply taken is compared with the oldest expected reply.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (reply_q.size() == 0) begin
        $error("reply with no request outstanding: status %0d", m_axis_tuser_o);
        mismatch_count++;
      end else begin
        head_reply = reply_q.pop_front();
        compare_field("status", head_reply.status, m_axis_tuser_o);
        compare_field("chosen_partition", head_reply.slot, m_axis_tdata_o[2:0]);
        compare_field("chosen_base", head_reply.base, m_axis_tdata_o[18:3]);
        compare_field("chosen_size", head_reply.span, m_axis_tdata_o[34:19]);
      end
    end
  end

  // Reply-side back-pressure in random bursts, always ready in the tail of the run.
  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      if (steady_tail) begin
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Stimulus.
  initial begin
    request_t req;
    reply_t   none;
    row_t     row;
    none           = '0;
    mismatch_count = 0;
    steady_tail    = 1'b0;
    for (int i = 0; i < bfpa_pkg::Partitions; i++) begin
      table_span[i]  = '0;
      table_base[i]  = '0;
      table_busy[i]  = 1'b0;
      table_owner[i] = '0;
    end
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;

    // Empty table, request size zero, unknown type, extremes and ties.
    add_row(bfpa_pkg::ReqAlloc,   0,  1,      0, 0,      0,      1,
            bfpa_pkg::StTooBig,    0, 0,      0);
    add_row(bfpa_pkg::ReqRelease, 5,  0,      0, 0,      0,      1,
            bfpa_pkg::StNothing,   0, 0,      0);
    add_row(ReqUnknown,           63, 'hFFFF, 7, 'hFFFF, 'hFFFF, 1,
            bfpa_pkg::StNothing,   0, 0,      0);
    add_row(bfpa_pkg::ReqAlloc,   63, 0,      0, 0,      0,      1,
            bfpa_pkg::StAllocated, 0, 0,      0);
    add_row(bfpa_pkg::ReqRelease, 63, 0,      0, 0,      0,      1,
            bfpa_pkg::StReleased,  0, 0,      0);
    add_row(bfpa_pkg::ReqDefine,  0,  0,      0, 0,      'hFFFF, 1,
            bfpa_pkg::StDefined,   0, 0,      'hFFFF);
    add_row(bfpa_pkg::ReqDefine,  0,  0,      7, 'hFFFF, 0,      1,
            bfpa_pkg::StDefined,   7, 'hFFFF, 0);
    add_row(bfpa_pkg::ReqAlloc,   1,  'hFFFF, 0, 0,      0,      0,
            bfpa_pkg::StNothing,   0, 0,      0);
    add_row(bfpa_pkg::ReqAlloc,   2,  'hFFFF, 0, 0,      0,      1,
            bfpa_pkg::StMemFull,   0, 0,      0);
    add_row(bfpa_pkg::ReqAlloc,   2,  0,      0, 0,      0,      0,
            bfpa_pkg::StNothing,   0, 0,      0);
    add_row(bfpa_pkg::ReqDefine,  0,  0,      1, 'h1000, 64,     1,
            bfpa_pkg::StDefined,   1, 'h1000, 64);
    add_row(bfpa_pkg::ReqDefine,  0,  0,      2, 'h2000, 64,     1,
            bfpa_pkg::StDefined,   2, 'h2000, 64);
    add_row(bfpa_pkg::ReqDefine,  0,  0,      3, 'h3000, 32,     1,
            bfpa_pkg::StDefined,   3, 'h3000, 32);
    add_row(bfpa_pkg::ReqAlloc,   3,  40,     0, 0,      0,      0,
            bfpa_pkg::StNothing,   0, 0,      0);
    add_row(bfpa_pkg::ReqAlloc,   4,  40,     0, 0,      0,      0,
            bfpa_pkg::StNothing,   0, 0,      0);
    add_row(bfpa_pkg::ReqAlloc,   5,  20,     0, 0,      0,      0,
            bfpa_pkg::StNothing,   0, 0,      0);
    add_row(bfpa_pkg::ReqAlloc,   6,  20,     0, 0,      0,      0,
            bfpa_pkg::StNothing,   0, 0,      0);
    add_row(bfpa_pkg::ReqRelease, 2,  0,      0, 0,      0,      0,
            bfpa_pkg::StNothing,   0, 0,      0);
    add_row(bfpa_pkg::ReqRelease, 1,  0,      0, 0,      0,      0,
            bfpa_pkg::StNothing,   0, 0,      0);
    add_row(bfpa_pkg::ReqAlloc,   7,  1,      0, 0,      0,      0,
            bfpa_pkg::StNothing,   0, 0,      0);
    add_row(bfpa_pkg::ReqAlloc,   7,  0,      0, 0,      0,      0,
            bfpa_pkg::StNothing,   0, 0,      0);
    add_row(bfpa_pkg::ReqRelease, 7,  0,      0, 0,      0,      0,
            bfpa_pkg::StNothing,   0, 0,      0);
    add_row(ReqUnknown,           42, 'h5555, 2, 'hAAAA, 'h5555, 1,
            bfpa_pkg::StNothing,   0, 0,      0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      request_gap(1'b0);
      send_request(row.req, row.known, row.reply);
    end

    // Random requests, with periodic full drains and a steady tail.
    for (int n = 0; n < RandomCount; n++) begin
      if (n == RandomCount - SteadyCount) steady_tail = 1'b1;
      request_gap(n % DrainEvery == 0);
      req = random_request();
      send_request(req, 1'b0, none);
    end
    s_axis_tvalid_i <= 1'b0;

    wait (reply_q.size() == 0);
    repeat (bfpa_pkg::Partitions + 4) @(posedge clk_i);
    if (mismatch_count == 0 && reply_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
